// File: sv/tst_pkg.sv
`timescale 1ns / 1ps

package tst_pkg;

  localparam int OPCODE_W  = 2;
  localparam int ADDR_HI_W = 16;
  localparam int ADDR_LO_W = 64;
  localparam int NUMBER_W  = 16;
  localparam int COUNT_W   = 5;

  // one stored entry: {address_upper, address_lower, last message number}
  localparam int ENTRY_W = ADDR_HI_W + ADDR_LO_W + NUMBER_W;

  localparam logic [OPCODE_W-1:0] OP_CONNECT    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DISCONNECT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CHECK      = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [ADDR_HI_W-1:0] address_upper;
    logic [ADDR_LO_W-1:0] address_lower;
    logic [NUMBER_W-1:0]  message_number;
  } tst_in_t;

  typedef struct packed {
    logic                was_present;
    logic [NUMBER_W-1:0] previous_number;
    logic                table_full;
    logic [COUNT_W-1:0]  connected_count;
  } tst_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } tst_state_t;

  typedef struct packed {
    logic clear;
    logic enable;
  } tst_cmp_ctl_t;

  typedef struct packed {
    logic hit;
    logic free_found;
  } tst_cmp_stat_t;

endpackage

// File: sv/tst_ram.sv
`timescale 1ns / 1ps

module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/tst_match.sv
`timescale 1ns / 1ps

module tst_match #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tst_pkg::tst_cmp_ctl_t            ctl,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] cmp_idx,
  input  logic                             ent_valid,
  input  logic [tst_pkg::ENTRY_W-1:0]      ent_data,
  input  logic [tst_pkg::ADDR_HI_W-1:0]    key_hi,
  input  logic [tst_pkg::ADDR_LO_W-1:0]    key_lo,
  output tst_pkg::tst_cmp_stat_t           stat,
  output logic [$clog2(TABLE_ENTRIES)-1:0] hit_idx,
  output logic [$clog2(TABLE_ENTRIES)-1:0] free_idx,
  output logic [tst_pkg::NUMBER_W-1:0]     prev_num
);

  import tst_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic                 hit_r, hit_nxt;
  logic                 free_r, free_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [NUMBER_W-1:0]  prev_r, prev_nxt;
  logic [ADDR_HI_W-1:0] ent_hi;
  logic [ADDR_LO_W-1:0] ent_lo;
  logic [NUMBER_W-1:0]  ent_num;
  logic                 addr_eq;

  assign {ent_hi, ent_lo, ent_num} = ent_data;
  assign addr_eq = (ent_hi == key_hi) && (ent_lo == key_lo);

  // keep only the first matching entry and the first free slot
  always_comb begin
    hit_nxt      = hit_r;
    free_nxt     = free_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    prev_nxt     = prev_r;
    if (ctl.clear) begin
      hit_nxt      = 1'b0;
      free_nxt     = 1'b0;
      hit_idx_nxt  = '0;
      free_idx_nxt = '0;
      prev_nxt     = '0;
    end else if (ctl.enable) begin
      if (ent_valid) begin
        if (!hit_r && addr_eq) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx;
          prev_nxt    = ent_num;
        end
      end else if (!free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      hit_idx_r  <= '0;
      free_idx_r <= '0;
      prev_r     <= '0;
    end else begin
      hit_r      <= hit_nxt;
      free_r     <= free_nxt;
      hit_idx_r  <= hit_idx_nxt;
      free_idx_r <= free_idx_nxt;
      prev_r     <= prev_nxt;
    end
  end

  assign stat.hit        = hit_r;
  assign stat.free_found = free_r;
  assign hit_idx         = hit_idx_r;
  assign free_idx        = free_idx_r;
  assign prev_num        = prev_r;

endmodule

// File: sv/terminal_session_table.sv
// An accepted item passes the sweep, drain and update states before its result is registered;
// no new item is taken until then. The sweep reads one table entry a cycle through the
// single read port of the entry RAM into one address comparator.
// A finished result waits in the output register while the next item is swept.
// Reset (synchronous, rst_n low) clears all valid bits and the connected count; the
// entry RAM is not cleared, its contents are only seen through a set valid bit.
`timescale 1ns / 1ps

module terminal_session_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tst_pkg::tst_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tst_pkg::tst_out_t out_data
);

  import tst_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  tst_state_t state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     cmp_pend_r;
  logic [IDX_W-1:0]         cmp_idx_r;
  tst_in_t                  item_r;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  tst_out_t                 out_data_r;

  logic                     rd_en;
  logic [ENTRY_W-1:0]       rd_data;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [ENTRY_W-1:0]       wr_data;
  tst_cmp_ctl_t             cmp_ctl;
  tst_cmp_stat_t            cmp_stat;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         free_idx;
  logic [NUMBER_W-1:0]      prev_num;
  logic                     upd_go;
  logic                     upd_en;
  logic                     do_connect;
  logic                     do_disconnect;
  logic                     do_check;
  logic                     is_full;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold the update while an earlier result still sits in the output register and out_stall is high
  assign upd_go = !out_valid_r || !out_stall;

  // state outputs
  always_comb begin
    in_stall       = 1'b1;
    rd_en          = 1'b0;
    upd_en         = 1'b0;
    cmp_ctl.clear  = 1'b0;
    cmp_ctl.enable = cmp_pend_r;
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmp_ctl.clear = 1'b1;
      end
      ST_SCAN: begin
        rd_en = 1'b1;
      end
      ST_DRAIN: begin
        rd_en = 1'b0;
      end
      ST_UPDATE: begin
        upd_en = upd_go;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (state_r == ST_IDLE) begin
      idx_nxt = '0;
    end else if (state_r == ST_SCAN && idx_r != LAST_IDX) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // table update
  assign do_connect    = (item_r.opcode == OP_CONNECT) && !cmp_stat.hit
                         && cmp_stat.free_found;
  assign is_full       = (item_r.opcode == OP_CONNECT) && !cmp_stat.hit
                         && !cmp_stat.free_found;
  assign do_disconnect = (item_r.opcode == OP_DISCONNECT) && cmp_stat.hit;
  assign do_check      = (item_r.opcode == OP_CHECK) && cmp_stat.hit;

  assign wr_en   = upd_en && (do_connect || do_check);
  assign wr_addr = do_connect ? free_idx : hit_idx;
  assign wr_data = {item_r.address_upper, item_r.address_lower, item_r.message_number};

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (upd_en) begin
      if (do_connect) begin
        valid_nxt[free_idx] = 1'b1;
        count_nxt           = count_r + 1'b1;
      end else if (do_disconnect) begin
        valid_nxt[hit_idx] = 1'b0;
        count_nxt          = count_r - 1'b1;
      end
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (upd_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cmp_pend_r  <= 1'b0;
      cmp_idx_r   <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cmp_pend_r  <= rd_en;
      cmp_idx_r   <= idx_r;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r <= in_data;
    end
    if (upd_en) begin
      out_data_r.was_present     <= cmp_stat.hit;
      out_data_r.previous_number <= prev_num;
      out_data_r.table_full      <= is_full;
      out_data_r.connected_count <= count_ext[COUNT_W-1:0];
    end
  end

  tst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  tst_match #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cmp_ctl),
    .cmp_idx   (cmp_idx_r),
    .ent_valid (valid_r[cmp_idx_r]),
    .ent_data  (rd_data),
    .key_hi    (item_r.address_upper),
    .key_lo    (item_r.address_lower),
    .stat      (cmp_stat),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx),
    .prev_num  (prev_num)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
